// File: src/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
// No dependencies; every other file in src imports this package.
package rrts_pkg;

    localparam int NUM_TASKS = 8;
    localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W     = $clog2(NUM_TASKS + 1);
    localparam int MASK_W    = (NUM_TASKS < 8) ? NUM_TASKS : 8;
    localparam int CMD_W     = 2;
    localparam int TICK_W    = 32;
    localparam int TASK_W    = 3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_DELAY  = 2'd1,
        CMD_SWITCH = 2'd2,
        CMD_CREATE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        SLOT_UNUSED  = 2'd0,
        SLOT_READY   = 2'd1,
        SLOT_BLOCKED = 2'd2
    } slot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAKE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             latch;
        logic             exec;
        logic             wake;
        logic             search;
        logic             load;
        logic [IDX_W-1:0] cnt;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic run_idle;
        logic found;
    } dp_status_t;

endpackage

// File: src/rrts_dpath.sv
// Datapath of the task scheduler: slot table, wake times, tick count and result register.
// Depends on rrts_pkg; driven by rrts_ctrl through ctrl_cmd_t.
module rrts_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrts_pkg::ctrl_cmd_t           ctl,
    output rrts_pkg::dp_status_t          sts,
    input  logic [rrts_pkg::CMD_W-1:0]    cmd,
    input  logic [rrts_pkg::TICK_W-1:0]   delay_ticks,
    output logic [rrts_pkg::TASK_W-1:0]   running_task,
    output logic                          status,
    output logic [7:0]                    ready_mask,
    output logic [rrts_pkg::TICK_W-1:0]   tick_now
);
    import rrts_pkg::*;

    slot_t             slot_state_reg [NUM_TASKS];
    slot_t             slot_state_next[NUM_TASKS];
    logic [TICK_W-1:0] wake_time_reg  [NUM_TASKS];
    logic [TICK_W-1:0] wake_time_next [NUM_TASKS];
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [IDX_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    cmd_t              cmd_reg, cmd_next;
    logic [TICK_W-1:0] dly_reg, dly_next;
    logic              status_reg, status_next;
    logic [TASK_W-1:0] task_out_reg;
    logic              status_out_reg;
    logic [7:0]        mask_out_reg, mask_out_next;
    logic [TICK_W-1:0] tick_out_reg;
    logic [IDX_W:0]    cursor_sum;
    logic [IDX_W-1:0]  cursor;
    logic              found;

    always_comb
    begin
        cursor_sum = {1'b0, run_reg} + (IDX_W + 1)'(1) + {1'b0, ctl.cnt};
        if (cursor_sum >= (IDX_W + 1)'(NUM_TASKS))
        begin
            cursor = IDX_W'(cursor_sum - (IDX_W + 1)'(NUM_TASKS));
        end
        else
        begin
            cursor = IDX_W'(cursor_sum);
        end
        found = (cursor != '0) && (slot_state_reg[cursor] == SLOT_READY);
    end

    always_comb
    begin
        sts.cmd      = cmd_reg;
        sts.run_idle = (run_reg == '0);
        sts.found    = found;
    end

    always_comb
    begin
        slot_state_next = slot_state_reg;
        wake_time_next  = wake_time_reg;
        tick_next       = tick_reg;
        run_next        = run_reg;
        used_next       = used_reg;
        cmd_next        = cmd_reg;
        dly_next        = dly_reg;
        status_next     = status_reg;

        if (ctl.latch)
        begin
            cmd_next = cmd_t'(cmd);
            dly_next = delay_ticks;
        end

        if (ctl.exec)
        begin
            status_next = 1'b0;
            case (cmd_reg)
                CMD_TICK:
                begin
                    tick_next = tick_reg + TICK_W'(1);
                end
                CMD_DELAY:
                begin
                    if (run_reg != '0)
                    begin
                        wake_time_next[run_reg]  = tick_reg + dly_reg;
                        slot_state_next[run_reg] = SLOT_BLOCKED;
                    end
                end
                CMD_SWITCH:
                begin
                end
                CMD_CREATE:
                begin
                    if (used_reg < CNT_W'(NUM_TASKS))
                    begin
                        slot_state_next[used_reg[IDX_W-1:0]] = SLOT_READY;
                        used_next = used_reg + CNT_W'(1);
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (ctl.wake)
        begin
            if ((slot_state_reg[ctl.cnt] != SLOT_READY) &&
                (wake_time_reg[ctl.cnt] == tick_reg))
            begin
                slot_state_next[ctl.cnt] = SLOT_READY;
            end
        end

        if (ctl.search)
        begin
            if (found)
            begin
                run_next = cursor;
            end
            else if (ctl.cnt == LAST_IDX)
            begin
                run_next = '0;
            end
        end
    end

    always_comb
    begin
        mask_out_next = '0;
        for (int i = 0; i < MASK_W; i++)
        begin
            mask_out_next[i] = (slot_state_reg[i] == SLOT_READY);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                slot_state_reg[i] <= SLOT_UNUSED;
                wake_time_reg[i]  <= '0;
            end
            tick_reg <= '0;
            run_reg  <= FIRST_IDX;
            used_reg <= '0;
        end
        else
        begin
            slot_state_reg <= slot_state_next;
            wake_time_reg  <= wake_time_next;
            tick_reg       <= tick_next;
            run_reg        <= run_next;
            used_reg       <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        dly_reg    <= dly_next;
        status_reg <= status_next;
        if (ctl.load)
        begin
            task_out_reg   <= TASK_W'(run_reg);
            status_out_reg <= status_reg;
            mask_out_reg   <= mask_out_next;
            tick_out_reg   <= tick_reg;
        end
    end

    assign running_task = task_out_reg;
    assign status       = status_out_reg;
    assign ready_mask   = mask_out_reg;
    assign tick_now     = tick_out_reg;

endmodule

// File: src/rrts_ctrl.sv
// Controller state machine of the task scheduler: sequences execute, wake scan and search.
// Depends on rrts_pkg; drives rrts_dpath through ctrl_cmd_t.
module rrts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  rrts_pkg::dp_status_t sts,
    output rrts_pkg::ctrl_cmd_t  ctl
);
    import rrts_pkg::*;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             load;

    assign load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (sts.cmd)
                    CMD_TICK:
                    begin
                        state_next = ST_WAKE;
                        cnt_next   = FIRST_IDX;
                    end
                    CMD_DELAY:
                    begin
                        state_next = sts.run_idle ? ST_DONE : ST_SEARCH;
                        cnt_next   = '0;
                    end
                    CMD_SWITCH:
                    begin
                        state_next = ST_SEARCH;
                        cnt_next   = '0;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WAKE:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_SEARCH;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_SEARCH:
            begin
                if (sts.found || (cnt_reg == LAST_IDX))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        out_valid  = out_valid_reg;
        ctl.latch  = (state_reg == ST_IDLE) && in_valid;
        ctl.exec   = (state_reg == ST_EXEC);
        ctl.wake   = (state_reg == ST_WAKE);
        ctl.search = (state_reg == ST_SEARCH);
        ctl.load   = load;
        ctl.cnt    = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler; joins rrts_ctrl and rrts_dpath.
// Depends on rrts_pkg, rrts_ctrl and rrts_dpath.
// One request at a time. A tick executes, then scans slots 1 to NUM_TASKS - 1 for wake-ups, then
// searches round robin, visiting k slots (1 to NUM_TASKS), one per cycle, before the result is loaded.
// A delay or switch executes and then searches; a create or a delay while idle only executes.
// The next request can be accepted in the cycle after the result is loaded, even if it waits.
// Reset clears all slots and wake times, the tick count and the result valid; slot 1 runs.
module round_robin_task_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rrts_pkg::CMD_W-1:0]    cmd,
    input  logic [rrts_pkg::TICK_W-1:0]   delay_ticks,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rrts_pkg::TASK_W-1:0]   running_task,
    output logic                          status,
    output logic [7:0]                    ready_mask,
    output logic [rrts_pkg::TICK_W-1:0]   tick_now
);
    import rrts_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t sts;

    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    rrts_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .cmd          (cmd),
        .delay_ticks  (delay_ticks),
        .running_task (running_task),
        .status       (status),
        .ready_mask   (ready_mask),
        .tick_now     (tick_now)
    );

endmodule

// File: src/rrts_chk.sv
// Port-level checker for the round-robin task scheduler, bound to the top level.
// Depends on rrts_pkg and round_robin_task_scheduler.
module rrts_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [rrts_pkg::TASK_W-1:0]   running_task,
    input logic                          status,
    input logic [7:0]                    ready_mask,
    input logic [rrts_pkg::TICK_W-1:0]   tick_now
);
    import rrts_pkg::*;

    logic [TICK_W-1:0] last_tick_reg;
    logic              out_take;

    assign out_take = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_tick_reg <= '0;
        end
        else if (out_take)
        begin
            last_tick_reg <= tick_now;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Result valid dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(running_task) && $stable(status) &&
                                   $stable(ready_mask) && $stable(tick_now))
        else $error("Result payload changed while stalled.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("A second request was accepted while one is in progress.");

    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_take |-> (tick_now == last_tick_reg) ||
                     (tick_now == last_tick_reg + TICK_W'(1)))
        else $error("Tick count advanced by more than one between results.");

endmodule

bind round_robin_task_scheduler rrts_chk u_rrts_chk (.*);

// File: tb/rrts_sched_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the round-robin task scheduler: watches both channels, predicts
// each result from its own scheduler state, and compares field by field.
// Depends on rrts_pkg.
module rrts_sched_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [rrts_pkg::CMD_W-1:0]  cmd,
    input  logic [rrts_pkg::TICK_W-1:0] delay_ticks,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [rrts_pkg::TASK_W-1:0] running_task,
    input  logic                        status,
    input  logic [7:0]                  ready_mask,
    input  logic [rrts_pkg::TICK_W-1:0] tick_now,
    output int                          mismatches,
    output int                          pending,
    output int                          requests_seen,
    output int                          results_checked,
    output int                          wakeups,
    output int                          idle_falls,
    output int                          refusals
);
    import rrts_pkg::*;

    typedef struct packed {
        logic [TASK_W-1:0] run_task;
        logic              refused;
        logic [7:0]        ready;
        logic [TICK_W-1:0] ticks;
    } sched_view_t;

    slot_t             slot_st [NUM_TASKS];
    logic [TICK_W-1:0] wake_at [NUM_TASKS];
    logic [TICK_W-1:0] tick_cnt;
    int                run_slot;
    int                created;
    sched_view_t       expected_views [$];
    sched_view_t       want;

    task automatic report_mismatch(string what, longint got, longint exp_val);
        mismatches++;
        $display("MISMATCH @%0t: %s got %0h expected %0h", $time, what, got, exp_val);
    endtask

    function automatic void rotate_to_next_ready();
        int  idx;
        int  n;
        bit  hit;
        idx = run_slot;
        hit = 1'b0;
        for (n = 0; n < NUM_TASKS; n++)
        begin
            idx = (idx + 1) % NUM_TASKS;
            if (!hit && idx != 0 && slot_st[idx] == SLOT_READY)
            begin
                run_slot = idx;
                hit = 1'b1;
            end
        end
        if (!hit)
        begin
            run_slot = 0;
            idle_falls++;
        end
    endfunction

    function automatic sched_view_t apply_command(cmd_t c, logic [TICK_W-1:0] d);
        sched_view_t v;
        int          i;
        bit          woke;
        v.refused = 1'b0;
        woke = 1'b0;
        case (c)
            CMD_TICK:
            begin
                tick_cnt = tick_cnt + 1;
                for (i = 1; i < NUM_TASKS; i++)
                begin
                    if (slot_st[i] != SLOT_READY && wake_at[i] == tick_cnt)
                    begin
                        slot_st[i] = SLOT_READY;
                        woke = 1'b1;
                    end
                end
                if (woke)
                    wakeups++;
                rotate_to_next_ready();
            end
            CMD_DELAY:
            begin
                if (run_slot != 0)
                begin
                    wake_at[run_slot] = tick_cnt + d;
                    slot_st[run_slot] = SLOT_BLOCKED;
                    rotate_to_next_ready();
                end
            end
            CMD_SWITCH:
            begin
                rotate_to_next_ready();
            end
            default:
            begin
                if (created < NUM_TASKS)
                begin
                    slot_st[created] = SLOT_READY;
                    created++;
                end
                else
                begin
                    v.refused = 1'b1;
                    refusals++;
                end
            end
        endcase
        v.ready = '0;
        for (i = 0; i < NUM_TASKS && i < 8; i++)
        begin
            if (slot_st[i] == SLOT_READY)
                v.ready[i] = 1'b1;
        end
        v.run_task = TASK_W'(run_slot);
        v.ticks = tick_cnt;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                slot_st[i] = SLOT_UNUSED;
                wake_at[i] = '0;
            end
            tick_cnt = '0;
            run_slot = 1 % NUM_TASKS;
            created = 0;
            expected_views.delete();
            mismatches = 0;
            requests_seen = 0;
            results_checked = 0;
            wakeups = 0;
            idle_falls = 0;
            refusals = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_views.size() == 0)
                begin
                    report_mismatch("result with no request outstanding", running_task, 0);
                end
                else
                begin
                    want = expected_views.pop_front();
                    results_checked++;
                    if (running_task !== want.run_task)
                        report_mismatch("running_task", running_task, want.run_task);
                    if (status !== want.refused)
                        report_mismatch("status", status, want.refused);
                    if (ready_mask !== want.ready)
                        report_mismatch("ready_mask", ready_mask, want.ready);
                    if (tick_now !== want.ticks)
                        report_mismatch("tick_now", tick_now, want.ticks);
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_views.push_back(apply_command(cmd_t'(cmd), delay_ticks));
                requests_seen++;
            end
            pending <= expected_views.size();
        end
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Top of the scheduler testbench: clock, reset, request stimulus and result stalls.
// Depends on rrts_pkg, round_robin_task_scheduler and rrts_sched_checker.
module tb_top;
    import rrts_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_COUNT = 950;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic [CMD_W-1:0]  cmd = CMD_TICK;
    logic [TICK_W-1:0] delay_ticks = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [TASK_W-1:0] running_task;
    logic              status;
    logic [7:0]        ready_mask;
    logic [TICK_W-1:0] tick_now;

    int mismatches;
    int pending;
    int requests_seen;
    int results_checked;
    int wakeups;
    int idle_falls;
    int refusals;

    bit hold_ask = 1'b0;
    int burst_left = 0;

    round_robin_task_scheduler i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .delay_ticks  (delay_ticks),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .running_task (running_task),
        .status       (status),
        .ready_mask   (ready_mask),
        .tick_now     (tick_now)
    );

    rrts_sched_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .delay_ticks     (delay_ticks),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .running_task    (running_task),
        .status          (status),
        .ready_mask      (ready_mask),
        .tick_now        (tick_now),
        .mismatches      (mismatches),
        .pending         (pending),
        .requests_seen   (requests_seen),
        .results_checked (results_checked),
        .wakeups         (wakeups),
        .idle_falls      (idle_falls),
        .refusals        (refusals)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic offer_request(cmd_t c, logic [TICK_W-1:0] d);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= c;
        delay_ticks <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                k;
        int                pick;
        cmd_t              c;
        logic [TICK_W-1:0] d;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // The first running slot was never created: a delay blocks it anyway,
        // and the tick that reaches its wake time readies it.
        offer_request(CMD_DELAY, 32'd2);
        offer_request(CMD_DELAY, 32'd5);
        offer_request(CMD_TICK, '0);
        offer_request(CMD_TICK, '0);
        offer_request(CMD_SWITCH, '0);
        repeat (9) offer_request(CMD_CREATE, '0);
        offer_request(CMD_SWITCH, '0);
        offer_request(CMD_DELAY, 32'hFFFF_FFFF);
        offer_request(CMD_DELAY, 32'h0000_0000);
        offer_request(CMD_TICK, 32'hFFFF_FFFF);
        offer_request(CMD_SWITCH, '0);
        offer_request(CMD_DELAY, 32'hAAAA_AAAA);
        offer_request(CMD_DELAY, 32'h5555_5555);
        offer_request(CMD_TICK, '0);
        offer_request(CMD_DELAY, 32'd1);
        offer_request(CMD_TICK, '0);
        offer_request(CMD_SWITCH, '0);
        wait_drained();

        for (k = 0; k < RANDOM_COUNT; k++)
        begin
            if (k == 320)
                hold_ask = 1'b1;
            if (k == 640)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 40)
                c = CMD_TICK;
            else if (pick < 68)
                c = CMD_DELAY;
            else if (pick < 88)
                c = CMD_SWITCH;
            else
                c = CMD_CREATE;
            pick = $urandom_range(0, 9);
            if (pick < 8)
                d = $urandom_range(0, 12);
            else if (pick == 8)
                d = $urandom_range(0, 200);
            else
                d = $urandom;
            offer_request(c, d);
        end

        wait_drained();
        repeat (40) @(posedge clk);
        $display("Covered %0d requests and %0d checked results, with %0d tick wake-ups,",
                 requests_seen, results_checked, wakeups);
        $display("%0d fallbacks to the idle task and %0d refused creates.",
                 idle_falls, refusals);
        if (mismatches == 0 && pending == 0)
            $display("round_robin_task_scheduler verification clean");
        else
            $display("round_robin_task_scheduler verification failed");
        $finish;
    end

    initial
    begin
        int hold_left;
        int mode;
        int mode_left;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_ask)
            begin
                hold_ask = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
        $display("round_robin_task_scheduler verification failed");
        $finish;
    end

endmodule
